/* rtl/sobel_edge_magnitude_rgb_assert.svh */
// ---------------------------------------------------------------------------
// sobel edge assertion macros
// shared concurrent assertion forms for the sobel edge block
// ---------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// implication checked on every edge outside reset
`define SEM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication outside reset
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sem_pkg.sv */
// ---------------------------------------------------------------------------
// sobel edge package
// shared constants and types of the sobel edge block
// ---------------------------------------------------------------------------
package sem_pkg;
	localparam int MaxWidth = 1024;
	localparam int ColW = $clog2(MaxWidth);
	localparam int StoreDepth = 3 * MaxWidth;
	localparam int AddrW = $clog2(StoreDepth);
	localparam int NumLanes = 3;
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;
	localparam logic [10:0] WIDTH_RESET = 11'd1024;
	localparam logic [15:0] HEIGHT_RESET = 16'd768;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// one 3x3 window, one channel
	typedef logic [8:0][7:0] win_t;

	typedef struct packed {
		logic line_end;
		logic frame_end;
		logic run_last;
	} flags_t;
endpackage

/* rtl/sem_in_if.sv */
// ---------------------------------------------------------------------------
// sobel edge input channel
// valid/ready channel carrying one pixel or drain word
// ---------------------------------------------------------------------------
interface sem_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
	modport sink (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

/* rtl/sem_out_if.sv */
// ---------------------------------------------------------------------------
// sobel edge output channel
// valid/ready channel carrying one edge result word
// ---------------------------------------------------------------------------
interface sem_out_if;
	logic valid;
	logic ready;
	logic [7:0] red_edge;
	logic [7:0] green_edge;
	logic [7:0] blue_edge;
	logic line_end;
	logic frame_end;
	logic run_last;
	modport source (output valid, red_edge, green_edge, blue_edge, line_end, frame_end,
		run_last, input ready);
	modport sink (input valid, red_edge, green_edge, blue_edge, line_end, frame_end,
		run_last, output ready);
endinterface

/* rtl/sobel_edge_magnitude_rgb.sv */
// ---------------------------------------------------------------------------
// sobel edge magnitude rgb
// streaming 3x3 sobel edge detector, three channel lanes, apb registers
// ---------------------------------------------------------------------------
// Takes 24-bit rgb pixels in raster order and gives per channel the rounded
// gradient magnitude, clamped to 255; borders count as zero. A pixel word
// produces up to two result words, a drain word one. Each result passes
// nine row store reads through the single ram read port, a wait for the
// last read to land, a start step, eight square root steps in each lane,
// a done step and the load of the output register. One word is in work at a
// time: a new pixel or drain word is taken only once the block is idle. A
// stalled output register holds the block in its output step until the word
// leaves.
// Registers: 0x0 image_width (11 bits), 0x4 image_height (16 bits); a write
// restarts the frame. The row store has no reset; it is always written before
// it is read.
`include "sobel_edge_magnitude_rgb_assert.svh"
module sobel_edge_magnitude_rgb (
	input  logic        clk,
	input  logic        arst_n,
	sem_in_if.sink      pix,
	sem_out_if.source   edge_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_READ = 5'b00010,
		ST_CALC = 5'b00100,
		ST_OUT  = 5'b01000,
		ST_WRT  = 5'b10000
	} state_t;

	localparam logic [2:0] ADDR_WIDTH = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;

	state_t state_q;
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [15:0] in_row_q;
	logic [sem_pkg::ColW-1:0] in_col_q, drain_col_q;
	logic frame_full_q;

	// job context of the word in work
	sem_pkg::rgb_t px_q;
	logic [15:0] cur_row_q;
	logic [15:0] orow_q;
	logic [sem_pkg::ColW-1:0] ocol_q;
	logic second_q;
	logic [3:0] rd_idx_q;
	logic rd_pend_q;
	logic [3:0] rd_tap_q;
	logic tap_ok_q;
	sem_pkg::win_t win_r_q, win_g_q, win_b_q;
	logic lanes_go;
	logic [2:0] lane_done;
	logic [2:0] done_seen_q;
	logic [7:0] mag [sem_pkg::NumLanes];
	sem_pkg::flags_t flags_q;

	logic [10:0] w_eff;
	logic [15:0] h_eff;
	logic [sem_pkg::ColW-1:0] wlast;
	logic cfg_wr;

	assign w_eff = (width_q == '0) ? 11'd1 :
		(width_q > 11'(sem_pkg::MaxWidth)) ? 11'(sem_pkg::MaxWidth) : width_q;
	assign h_eff = (height_q == '0) ? 16'd1 : height_q;
	assign wlast = sem_pkg::ColW'(w_eff - 11'd1);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr)
			ADDR_WIDTH:  prdata = {21'd0, width_q};
			ADDR_HEIGHT: prdata = {16'd0, height_q};
			default:     prdata = '0;
		endcase
	end

	// ---------------- row store ----------------
	logic we;
	logic [sem_pkg::AddrW-1:0] waddr, raddr;
	logic [23:0] rdata;
	logic [15:0] tr;
	logic [sem_pkg::ColW-1:0] tc;
	logic signed [17:0] tr_s;
	logic signed [11:0] tc_s;
	logic tap_ok;
	logic [1:0] tr_mod;

	function automatic logic [1:0] mod3(input logic [15:0] v);
		logic [15:0] q;
		q = 16'((32'(v) * 32'd43691) >> 17);
		return 2'(v - 16'(q * 16'd3));
	endfunction

	assign we = (state_q == ST_WRT);
	assign waddr = sem_pkg::AddrW'(32'(mod3(cur_row_q)) * sem_pkg::MaxWidth + 32'(in_col_q));

	// tap for read index: row = orow + idx/3 - 1, col = ocol + idx%3 - 1
	always_comb begin
		logic [1:0] dr, dc;
		dr = (rd_idx_q >= 4'd6) ? 2'd2 : (rd_idx_q >= 4'd3) ? 2'd1 : 2'd0;
		dc = 2'(rd_idx_q - 4'(dr) * 4'd3);
		tr_s = 18'(signed'({2'b0, orow_q})) + 18'(signed'({16'd0, dr})) - 18'sd1;
		tc_s = 12'(signed'({2'b0, ocol_q})) + 12'(signed'({10'd0, dc})) - 12'sd1;
		tr = tr_s[15:0];
		tc = tc_s[sem_pkg::ColW-1:0];
		tap_ok = !tr_s[17] && !tc_s[11] && (tr_s[16:0] < 17'(h_eff))
			&& (11'(tc_s[10:0]) < w_eff);
		tr_mod = mod3(tr);
	end
	assign raddr = sem_pkg::AddrW'(32'(tr_mod) * sem_pkg::MaxWidth + 32'(tc));

	sem_ram #(.Width(24), .Depth(sem_pkg::StoreDepth)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(px_q), .raddr(raddr), .rdata(rdata)
	);

	// ---------------- lanes ----------------
	sem_lane u_lane_r (.clk(clk), .arst_n(arst_n), .start(lanes_go), .win(win_r_q),
		.done(lane_done[0]), .mag(mag[0]));
	sem_lane u_lane_g (.clk(clk), .arst_n(arst_n), .start(lanes_go), .win(win_g_q),
		.done(lane_done[1]), .mag(mag[1]));
	sem_lane u_lane_b (.clk(clk), .arst_n(arst_n), .start(lanes_go), .win(win_b_q),
		.done(lane_done[2]), .mag(mag[2]));

	assign lanes_go = (state_q == ST_CALC) && !rd_pend_q && (rd_idx_q == 4'd9)
		&& (done_seen_q == 3'b111);

	// ---------------- merge / output register ----------------
	logic out_valid_q;
	logic [7:0] out_r_q, out_g_q, out_b_q;
	logic load_out;
	assign edge_out.valid = out_valid_q;
	assign edge_out.red_edge = out_r_q;
	assign edge_out.green_edge = out_g_q;
	assign edge_out.blue_edge = out_b_q;
	assign edge_out.line_end = flags_q.line_end;
	assign edge_out.frame_end = flags_q.frame_end;
	assign edge_out.run_last = flags_q.run_last;

	// lane results move to the output register only once it is empty or its word leaves
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || edge_out.ready);

	// no word taken during a register write
	assign pix.ready = (state_q == ST_IDLE) && !cfg_wr;

	logic acc;
	logic [sem_pkg::ColW-1:0] col_c;
	logic need1, need2;
	assign acc = pix.valid && pix.ready;
	// in_col is always below width after a restart; width only changes with restart
	assign col_c = in_col_q;
	assign need1 = (in_row_q != 16'd0) && (col_c != '0);
	assign need2 = (in_row_q != 16'd0) && (col_c == wlast);

	always_ff @(posedge clk) begin
		if (acc) begin
			px_q <= {pix.red_in, pix.green_in, pix.blue_in};
		end
		if (rd_pend_q) begin
			win_r_q[rd_tap_q] <= tap_ok_q ? rdata[23:16] : 8'd0;
			win_g_q[rd_tap_q] <= tap_ok_q ? rdata[15:8] : 8'd0;
			win_b_q[rd_tap_q] <= tap_ok_q ? rdata[7:0] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			width_q <= sem_pkg::WIDTH_RESET;
			height_q <= sem_pkg::HEIGHT_RESET;
			in_row_q <= '0;
			in_col_q <= '0;
			drain_col_q <= '0;
			frame_full_q <= 1'b0;
			cur_row_q <= '0;
			orow_q <= '0;
			ocol_q <= '0;
			second_q <= 1'b0;
			rd_idx_q <= '0;
			rd_pend_q <= 1'b0;
			rd_tap_q <= '0;
			tap_ok_q <= 1'b0;
			done_seen_q <= 3'b111;
			out_valid_q <= 1'b0;
			out_r_q <= '0;
			out_g_q <= '0;
			out_b_q <= '0;
			flags_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				out_r_q <= mag[0];
				out_g_q <= mag[1];
				out_b_q <= mag[2];
				flags_q.line_end <= (ocol_q == wlast);
				flags_q.frame_end <= (ocol_q == wlast) && (orow_q == h_eff - 16'd1);
				flags_q.run_last <= !second_q;
			end else if (edge_out.valid && edge_out.ready) begin
				out_valid_q <= 1'b0;
			end
			rd_pend_q <= (state_q == ST_READ) && !cfg_wr;
			if (cfg_wr) begin
				if (paddr == ADDR_WIDTH) width_q <= pwdata[10:0];
				if (paddr == ADDR_HEIGHT) height_q <= pwdata[15:0];
				in_row_q <= '0;
				in_col_q <= '0;
				drain_col_q <= '0;
				frame_full_q <= 1'b0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (acc) begin
							if (pix.opcode == sem_pkg::OP_PIXEL && !frame_full_q) begin
								cur_row_q <= in_row_q;
								state_q <= ST_WRT;
							end else if (pix.opcode == sem_pkg::OP_DRAIN && frame_full_q) begin
								orow_q <= h_eff - 16'd1;
								ocol_q <= drain_col_q;
								second_q <= 1'b0;
								rd_idx_q <= '0;
								done_seen_q <= 3'b000;
								state_q <= ST_READ;
								if (drain_col_q == wlast) begin
									in_row_q <= '0;
									in_col_q <= '0;
									drain_col_q <= '0;
									frame_full_q <= 1'b0;
								end else begin
									drain_col_q <= drain_col_q + 1'b1;
								end
							end
						end
					end
					ST_WRT: begin
						// store written this cycle, then start the first result if one is due
						orow_q <= in_row_q - 16'd1;
						ocol_q <= need1 ? col_c - 1'b1 : wlast;
						second_q <= need1 && need2;
						rd_idx_q <= '0;
						done_seen_q <= 3'b000;
						state_q <= (need1 || need2) ? ST_READ : ST_IDLE;
						if (col_c == wlast) begin
							in_col_q <= '0;
							if (in_row_q >= h_eff - 16'd1) frame_full_q <= 1'b1;
							else in_row_q <= in_row_q + 16'd1;
						end else begin
							in_col_q <= in_col_q + 1'b1;
						end
					end
					ST_READ: begin
						rd_tap_q <= rd_idx_q;
						tap_ok_q <= tap_ok;
						rd_idx_q <= rd_idx_q + 4'd1;
						if (rd_idx_q == 4'd8) begin
							done_seen_q <= 3'b111;
							state_q <= ST_CALC;
						end
					end
					ST_CALC: begin
						if (lanes_go) begin
							done_seen_q <= 3'b000;
							rd_idx_q <= 4'd10;
						end
						if (lane_done[0]) begin
							state_q <= ST_OUT;
						end
					end
					ST_OUT: begin
						if (load_out) begin
							if (second_q) begin
								second_q <= 1'b0;
								ocol_q <= wlast;
								rd_idx_q <= '0;
								state_q <= ST_READ;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	`SEM_ASSERT_IMP(a_ready_idle, pix.ready, !out_valid_q || state_q == ST_IDLE,
		"ready outside idle")
	`SEM_ASSERT_NEXT(a_out_hold, edge_out.valid && !edge_out.ready,
		edge_out.valid && $stable(edge_out.red_edge), "stalled result changed")
	`SEM_ASSERT_IMP(a_lanes_sync, lane_done[0], lane_done[1] && lane_done[2],
		"lanes out of step")
endmodule

/* rtl/sem_ram.sv */
// ---------------------------------------------------------------------------
// sobel edge generic ram
// single write port, single registered read port
// ---------------------------------------------------------------------------
module sem_ram #(
	parameter int Width = 24,
	parameter int Depth = 3072
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/sem_lane.sv */
// ---------------------------------------------------------------------------
// sobel edge lane
// one channel: gradients, sum of squares, iterative rounded root
// ---------------------------------------------------------------------------
module sem_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sem_pkg::win_t     win,
	output logic              done,
	output logic [7:0]        mag
);
	logic signed [11:0] gx_c, gy_c;
	logic [20:0] s_q;
	logic [7:0] n_q;
	logic [7:0] bit_q;
	logic busy_q;
	logic [7:0] trial;
	logic [16:0] tsq;

	// win index: row*3+col, row 0 top
	always_comb begin
		gx_c = 12'(signed'({4'd0, win[2]})) - 12'(signed'({4'd0, win[0]}))
			+ 12'(signed'({3'd0, win[5], 1'b0})) - 12'(signed'({3'd0, win[3], 1'b0}))
			+ 12'(signed'({4'd0, win[8]})) - 12'(signed'({4'd0, win[6]}));
		gy_c = 12'(signed'({4'd0, win[6]})) - 12'(signed'({4'd0, win[0]}))
			+ 12'(signed'({3'd0, win[7], 1'b0})) - 12'(signed'({3'd0, win[1], 1'b0}))
			+ 12'(signed'({4'd0, win[8]})) - 12'(signed'({4'd0, win[2]}));
	end

	// find largest n with n*n+n < s, answer n+1 (0 for s = 0, clamped to 255), one bit per cycle
	assign trial = n_q | bit_q;
	assign tsq = 17'(trial) * 17'(trial) + 17'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			bit_q <= '0;
		end else begin
			done <= !start && busy_q && bit_q[0];
			if (start) begin
				busy_q <= 1'b1;
				bit_q <= 8'h80;
			end else if (busy_q) begin
				bit_q <= bit_q >> 1;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= 21'(gx_c * gx_c) + 21'(gy_c * gy_c);
			n_q <= '0;
		end else if (busy_q && (21'(tsq) < s_q)) begin
			n_q <= trial;
		end
	end

	always_comb begin
		if (s_q == '0) mag = 8'd0;
		else if (n_q == 8'd255) mag = 8'd255;
		else mag = n_q + 8'd1;
	end
endmodule
